// File: rtl/core/tpd_pkg.sv
`default_nettype none

package tpd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int GAIN_W  = 16;
  localparam int THR_W   = 13;
  localparam int OGAIN_W = 15;
  localparam int BLK_W   = 16;
  localparam int PW_W    = 16;
  localparam int OSF_W   = 7;
  localparam int DVS_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OS_FACTOR   = 3'd5;

  typedef struct packed {
    logic [GAIN_W-1:0]         input_gain;
    logic signed [THR_W-1:0]   threshold;
    logic [OGAIN_W-1:0]        output_gain;
    logic [BLK_W-1:0]          block_size;
    logic [PW_W-1:0]           pulse_width;
    logic [OSF_W-1:0]          os_factor;
  } tpd_cfg_t;

  localparam tpd_cfg_t CFG_RESET = '{
    input_gain:  16'd32768,
    threshold:   13'sd0,
    output_gain: 15'd32767,
    block_size:  16'd4800,
    pulse_width: 16'd375,
    os_factor:   7'd1
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_CMP,
    S_LVL,
    S_DIV,
    S_EDGE,
    S_LOAD,
    S_TICK,
    S_OMUL,
    S_OPROD,
    S_ODIV,
    S_OUT
  } tpd_state_t;

endpackage

`default_nettype wire

// File: rtl/core/tpd_cfg.sv
`default_nettype none

module tpd_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [tpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tpd_pkg::tpd_cfg_t                    cfg_o
);

  tpd_pkg::tpd_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        tpd_pkg::REG_INPUT_GAIN:  cfg_nxt.input_gain  = cfg_data[tpd_pkg::GAIN_W-1:0];
        tpd_pkg::REG_THRESHOLD:   cfg_nxt.threshold   = $signed(cfg_data[tpd_pkg::THR_W-1:0]);
        tpd_pkg::REG_OUTPUT_GAIN: cfg_nxt.output_gain = cfg_data[tpd_pkg::OGAIN_W-1:0];
        tpd_pkg::REG_BLOCK_SIZE:  cfg_nxt.block_size  = cfg_data[tpd_pkg::BLK_W-1:0];
        tpd_pkg::REG_PULSE_WIDTH: cfg_nxt.pulse_width = cfg_data[tpd_pkg::PW_W-1:0];
        tpd_pkg::REG_OS_FACTOR:   cfg_nxt.os_factor   = cfg_data[tpd_pkg::OSF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tpd_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

// File: rtl/core/tpd_mul.sv
`default_nettype none

module tpd_mul #(
  parameter int A_W = 17,
  parameter int B_W = 17
) (
  input  wire logic                   clk,
  input  wire logic signed [A_W-1:0]  a,
  input  wire logic signed [B_W-1:0]  b,
  output logic signed [A_W+B_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

`default_nettype wire

// File: rtl/core/tpd_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the upper DVS_W bits of the dividend are below the divisor.
module tpd_div #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      start,
  input  wire logic [SAMPLE_BITS+tpd_pkg::DVS_W-1:0]     dvd,
  input  wire logic [tpd_pkg::DVS_W-1:0]                 dvs,
  output logic                                           busy,
  output logic [SAMPLE_BITS-1:0]                         quo
);

  localparam int QW    = SAMPLE_BITS;
  localparam int DW    = tpd_pkg::DVS_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    dvs_r, dvs_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DW+1:0]    diff;

  always_comb begin
    diff     = {1'b0, rem_r, quo_r[QW-1]} - {2'b00, dvs_r};
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = dvd[QW+DW-1:QW];
      quo_nxt  = dvd[QW-1:0];
      dvs_nxt  = dvs;
      cnt_nxt  = CNT_W'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // keep the shifted remainder on borrow
      rem_nxt  = diff[DW+1] ? {rem_r[DW-2:0], quo_r[QW-1]} : diff[DW-1:0];
      quo_nxt  = {quo_r[QW-2:0], ~diff[DW+1]};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// File: rtl/core/threshold_pulse_drive.sv
`default_nettype none

// Threshold-triggered pulse generator, one result per sample.
// in_*  : sample transaction; tdata holds the signed sample, tuser the channel.
// out_* : result transaction; tdata holds the signed pulse sample, tuser the channel.
// cfg_* : register write channel, always ready; write only while the block is idle.
// Each sample is scaled, compared with the threshold and folded into its
// channel's level mean; a change of the compare state reloads the channel's
// pulse counter, and the sample spends up to oversampling_factor ticks of it.
// A sample is accepted only in the idle state, so a new sample waits until the
// result of the last one has been loaded into the output register. A reload of
// the pulse counter adds the load step; the sample that closes a level block
// adds a pass of the shared radix-2 divider unless its mean clamps to full
// scale. The divider works out one quotient bit per cycle; in_tready is high
// only between samples.
// A finished result waits in the output register; while the receiver stalls,
// the next sample runs up to its last step and holds there.
// Reset (rst_n low, synchronous) restores the register defaults and clears all
// channel level, compare and pulse state.
module threshold_pulse_drive #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,   // sample_in
  input  wire logic                                  in_tuser,   // channel_sel
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]           out_tdata,  // sample_out
  output logic                                       out_tuser,  // channel_out
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [tpd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [tpd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int SB     = SAMPLE_BITS;
  localparam int DATA_W = ((SB + 7) / 8) * 8;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W  = SB + 15;
  localparam int DVD_W  = SB + tpd_pkg::DVS_W;
  localparam int MA_W   = SB + 1;
  localparam int MB_W   = 17;
  localparam int P_W    = MA_W + MB_W;
  localparam int TW     = SB + 13;
  localparam int SH_UP  = (SB >= 16) ? SB - 16 : 0;
  localparam int SH_DN  = (SB < 16) ? 16 - SB : 0;
  localparam int PW_W   = tpd_pkg::PW_W;
  localparam int OSF_W  = tpd_pkg::OSF_W;
  localparam int BLK_W  = tpd_pkg::BLK_W;

  localparam logic [SB-1:0]   ONE = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB+15:0]  RND = (SB+16)'((1 << (SB - 1)) - 1);

  tpd_pkg::tpd_cfg_t   cfg;
  tpd_pkg::tpd_state_t state_r, state_nxt;

  // per-channel state
  logic [SUM_W-1:0]  sum_r   [CHANNELS];
  logic [BLK_W-1:0]  cnt_r   [CHANNELS];
  logic [SB-1:0]     mean_r  [CHANNELS];
  logic              above_r [CHANNELS];
  logic [PW_W-1:0]   rem_r   [CHANNELS];

  // current item
  logic signed [SB-1:0] s_r;
  logic [CH_W-1:0]      ch_r;
  logic [CH_W-1:0]      ch_in;
  logic                 st_r;
  logic [OSF_W-1:0]     act_r;

  logic                 out_valid_r;
  logic [SB-1:0]        out_data_r;
  logic                 out_ch_r;
  logic                 out_load;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  prod_r;

  logic                 div_start;
  logic [DVD_W-1:0]     div_dvd;
  logic [BLK_W-1:0]     div_dvs;
  logic                 div_busy;
  logic [SB-1:0]        div_q;

  logic signed [SB-1:0] scaled;
  logic signed [TW-1:0] thr_ext, thr_v, scaled_ext;
  logic                 thr_neg;
  logic                 st_nxt;
  logic [SB-1:0]        mag;
  logic [SUM_W-1:0]     sum_add;
  logic [BLK_W-1:0]     cnt_add;
  logic [BLK_W-1:0]     blk;
  logic [DVD_W-1:0]     lim;
  logic                 blk_end;
  logic                 clamp;
  logic [OSF_W-1:0]     fac;
  logic [OSF_W-1:0]     act_nxt;
  logic [SB+14:0]       og_wide;
  logic [SB-2:0]        og_s;
  logic [SB+15:0]       load_sum;
  logic [SB-1:0]        res;
  logic                 pulse_edge;

  tpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  tpd_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  tpd_div #(
    .SAMPLE_BITS (SB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .busy  (div_busy),
    .quo   (div_q)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == tpd_pkg::S_IDLE);
  assign ch_in     = (CHANNELS == 1) ? '0 : CH_W'(in_tuser);

  // compare path
  assign scaled     = $signed(prod_r[SB+15:16]);
  assign thr_neg    = cfg.threshold[tpd_pkg::THR_W-1];
  assign thr_ext    = TW'($signed(cfg.threshold));
  assign thr_v      = (thr_ext <<< SH_UP) >>> SH_DN;
  assign scaled_ext = TW'(scaled);
  assign st_nxt     = thr_neg ? (scaled_ext < thr_v) : (scaled_ext > thr_v);
  assign mag        = scaled[SB-1] ? (~scaled + 1'b1) : scaled;

  // level averaging
  assign sum_add = sum_r[ch_r] + SUM_W'(mag);
  assign cnt_add = cnt_r[ch_r] + 1'b1;
  assign blk     = (cfg.block_size == '0) ? BLK_W'(1) : cfg.block_size;
  assign lim     = (DVD_W'(blk) << (SB - 1)) + DVD_W'(blk);
  assign blk_end = (cnt_r[ch_r] >= blk);
  assign clamp   = (DVD_W'(sum_r[ch_r]) >= lim);

  // pulse and output
  assign pulse_edge = (st_r != above_r[ch_r]);
  assign load_sum   = prod_r[SB+15:0] + RND;
  assign fac        = (cfg.os_factor == '0) ? OSF_W'(1) : cfg.os_factor;
  assign act_nxt    = (rem_r[ch_r] < PW_W'(fac)) ? rem_r[ch_r][OSF_W-1:0] : fac;
  assign og_wide    = (SB+15)'(cfg.output_gain) << SH_UP;
  assign og_s       = (SB-1)'(og_wide >> SH_DN);
  assign res        = thr_neg ? (~div_q + 1'b1) : div_q;
  assign out_load   = (state_r == tpd_pkg::S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_r)
      tpd_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = tpd_pkg::S_SCALE;
        end
      end
      tpd_pkg::S_SCALE: begin
        mul_a     = MA_W'(s_r);
        mul_b     = $signed({1'b0, cfg.input_gain});
        state_nxt = tpd_pkg::S_CMP;
      end
      tpd_pkg::S_CMP: begin
        state_nxt = tpd_pkg::S_LVL;
      end
      tpd_pkg::S_LVL: begin
        if (blk_end && !clamp) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(sum_r[ch_r]);
          div_dvs   = blk;
          state_nxt = tpd_pkg::S_DIV;
        end else begin
          state_nxt = tpd_pkg::S_EDGE;
        end
      end
      tpd_pkg::S_DIV: begin
        if (!div_busy) begin
          state_nxt = tpd_pkg::S_EDGE;
        end
      end
      tpd_pkg::S_EDGE: begin
        if (pulse_edge) begin
          mul_a     = $signed({1'b0, mean_r[ch_r]});
          mul_b     = $signed({1'b0, cfg.pulse_width});
          state_nxt = tpd_pkg::S_LOAD;
        end else begin
          state_nxt = tpd_pkg::S_TICK;
        end
      end
      tpd_pkg::S_LOAD: begin
        state_nxt = tpd_pkg::S_TICK;
      end
      tpd_pkg::S_TICK: begin
        state_nxt = tpd_pkg::S_OMUL;
      end
      tpd_pkg::S_OMUL: begin
        mul_a     = $signed({2'b00, og_s});
        mul_b     = $signed({10'b0, act_r});
        state_nxt = tpd_pkg::S_OPROD;
      end
      tpd_pkg::S_OPROD: begin
        div_start = 1'b1;
        div_dvd   = prod_r[DVD_W-1:0];
        div_dvs   = BLK_W'(fac);
        state_nxt = tpd_pkg::S_ODIV;
      end
      tpd_pkg::S_ODIV: begin
        if (!div_busy) begin
          state_nxt = tpd_pkg::S_OUT;
        end
      end
      tpd_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = tpd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tpd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sum_r[c]   <= '0;
        cnt_r[c]   <= '0;
        mean_r[c]  <= '0;
        above_r[c] <= 1'b0;
        rem_r[c]   <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        tpd_pkg::S_CMP: begin
          sum_r[ch_r] <= sum_add;
          cnt_r[ch_r] <= cnt_add;
        end
        tpd_pkg::S_LVL: begin
          // mean above full scale: clamp without dividing
          if (blk_end && clamp) begin
            mean_r[ch_r] <= ONE;
            sum_r[ch_r]  <= '0;
            cnt_r[ch_r]  <= '0;
          end
        end
        tpd_pkg::S_DIV: begin
          if (!div_busy) begin
            mean_r[ch_r] <= div_q;
            sum_r[ch_r]  <= '0;
            cnt_r[ch_r]  <= '0;
          end
        end
        tpd_pkg::S_EDGE: begin
          if (pulse_edge) begin
            above_r[ch_r] <= st_r;
          end
        end
        tpd_pkg::S_LOAD: begin
          rem_r[ch_r] <= load_sum[SB+14:SB-1];
        end
        tpd_pkg::S_TICK: begin
          rem_r[ch_r] <= rem_r[ch_r] - PW_W'(act_nxt);
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_r  <= $signed(in_tdata[SB-1:0]);
      ch_r <= ch_in;
    end
    if (state_r == tpd_pkg::S_CMP) begin
      st_r <= st_nxt;
    end
    if (state_r == tpd_pkg::S_TICK) begin
      act_r <= act_nxt;
    end
    if (out_load) begin
      out_data_r <= res;
      out_ch_r   <= ch_r[0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);
  assign out_tuser  = out_ch_r;

  a_mean_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != tpd_pkg::S_IDLE |-> mean_r[ch_r] <= ONE)
    else $error("channel mean above full scale");

  a_count_below_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tpd_pkg::S_EDGE |-> cnt_r[ch_r] < blk)
    else $error("level count not wrapped at block end");

  a_div_free_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_out_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == tpd_pkg::S_OUT))
    else $error("result presented outside the output step");

endmodule

`default_nettype wire
